/* src/rsn_pkg.sv */
// shared constants, register indexes and types for the range scan segment finder
// no dependencies; imported by rsn_div, range_scan_nearest_segment_top and the testbench
`timescale 1ns / 1ps
`default_nettype none

package rsn_pkg;

  localparam int RANGE_W = 16;
  localparam int ANG_W   = 9;
  localparam int SUM_W   = 25;
  localparam int CFG_IDX_W = 2;

  localparam int MAX_SAMPLES_DEF = 512;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [RANGE_W-1:0] RANGE_SAT = {RANGE_W{1'b1}};

  localparam logic [RANGE_W-1:0] MIN_RANGE_RST  = 16'd10;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST  = 16'd3000;
  localparam logic [ANG_W-1:0]   LOW_BOUND_RST  = 9'd30;
  localparam logic [ANG_W-1:0]   HIGH_BOUND_RST = 9'd150;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUND  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUND = 2'd3;

  // divider status toward the sequencer
  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quot;
  } rsn_div_res_t;

endpackage

`default_nettype wire

/* src/rsn_div.sv */
// bit-serial restoring divider: one quotient bit per cycle, dividend shifted msb first
// depends on rsn_pkg for the sum width and the result struct
`timescale 1ns / 1ps
`default_nettype none

module rsn_div #(
  parameter int DIV_W = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [rsn_pkg::SUM_W-1:0] dividend,
  input  wire logic [DIV_W-1:0]         divisor,
  output rsn_pkg::rsn_div_res_t         res
);
  import rsn_pkg::*;

  localparam int STEP_W = $clog2(SUM_W);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  dq;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dvs;

  logic [DIV_W:0]    rem_sh;
  logic              ge;
  logic [DIV_W-1:0]  rem_next;
  logic [SUM_W-1:0]  dq_next;

  always_comb begin
    rem_sh   = {rem, dq[SUM_W-1]};
    ge       = (rem_sh >= {1'b0, dvs});
    rem_next = ge ? DIV_W'(rem_sh - {1'b0, dvs}) : rem_sh[DIV_W-1:0];
    dq_next  = {dq[SUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        step <= STEP_W'(SUM_W - 1);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= dq_next;
      rem <= rem_next;
    end
  end

  assign res.done = done;
  assign res.quot = dq;

endmodule

`default_nettype wire

/* src/range_scan_nearest_segment_top.sv */
// top level of the range scan nearest segment finder: sequencer, scan state, outputs
// depends on rsn_pkg and rsn_div
`timescale 1ns / 1ps
`default_nettype none

// Takes one range sample (mm) per item; the sample position in the scan is its
// angle. A segment opens on min_range < range < max_range, accumulates every
// sample while open and closes on the first range > max_range. On close the
// segment mean (sum / sample count) is formed by a bit-serial divider, one
// quotient bit per cycle. On the item marked last_sample one result item is
// produced: the nearest segment with start < low_angle_bound or end >
// high_angle_bound (earliest wins on ties), else the first segment, else
// found = 0 with distance 65535; a segment still open is dropped and the scan
// restarts. Timing: an item that does not close a segment completes in the
// cycle it is accepted; an item that closes a segment holds the input until the
// divider has loaded its operands and run all its steps, and the scan state is
// updated from its result. A last item is taken only when the output register
// is free or being emptied in that cycle; other items are taken while a result
// still waits. Configuration writes take effect on the next edge and are meant
// for idle periods only.
module range_scan_nearest_segment_top #(
  parameter int MAX_SAMPLES = rsn_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // sample channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rsn_pkg::RANGE_W-1:0]  range_mm,
  input  wire logic                         last_sample,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              found,
  output logic [rsn_pkg::ANG_W-1:0]         start_angle,
  output logic [rsn_pkg::ANG_W-1:0]         end_angle,
  output logic [rsn_pkg::RANGE_W-1:0]       distance_mm,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [rsn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rsn_pkg::RANGE_W-1:0]  cfg_data
);
  import rsn_pkg::*;

  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  // common width for comparing indexes against the 9 bit angle bounds
  localparam int CW    = (IDX_W > ANG_W) ? IDX_W : ANG_W;

  typedef enum logic {ST_IDLE, ST_DIV} state_t;

  state_t state;

  // configuration registers
  logic [RANGE_W-1:0] min_range;
  logic [RANGE_W-1:0] max_range;
  logic [ANG_W-1:0]   low_angle_bound;
  logic [ANG_W-1:0]   high_angle_bound;

  // scan state
  logic [IDX_W-1:0]   sample_index, sample_index_next;
  logic               in_segment, in_segment_next;
  logic [IDX_W-1:0]   segment_start, segment_start_next;
  logic [SUM_W-1:0]   segment_sum, segment_sum_next;
  logic               any_segment, any_segment_next;
  logic [IDX_W-1:0]   first_start, first_start_next;
  logic [IDX_W-1:0]   first_end, first_end_next;
  logic [RANGE_W-1:0] first_dist, first_dist_next;
  logic               have_candidate, have_candidate_next;
  logic [IDX_W-1:0]   best_start, best_start_next;
  logic [IDX_W-1:0]   best_end, best_end_next;
  logic [RANGE_W-1:0] best_dist, best_dist_next;
  logic               last_q;

  // sequencer controls
  logic               accept;
  logic               closes;
  logic               opens;
  logic               finish;
  logic               emit;
  logic               scan_last;
  logic               div_start;
  rsn_div_res_t       div_res;

  // close arithmetic
  logic [CNT_W-1:0]   cnt_diff;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   seg_end;
  logic [RANGE_W-1:0] mean;
  logic               in_bound;
  logic [SUM_W:0]     sum_add;

  logic               found_next;
  logic [ANG_W-1:0]   start_angle_next;
  logic [ANG_W-1:0]   end_angle_next;
  logic [RANGE_W-1:0] distance_mm_next;

  // a last item needs the output register free by the edge it is taken
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready || !last_sample);
  assign accept   = in_valid && in_ready;
  assign opens    = !in_segment && (range_mm > min_range) && (range_mm < max_range);
  assign closes   = in_segment && (range_mm > max_range);
  assign div_start = accept && closes;

  // item completes now, or after the divider for a closing item
  assign finish    = (accept && !closes) || (state == ST_DIV && div_res.done);
  assign scan_last = (state == ST_DIV) ? last_q : last_sample;
  assign emit      = finish && scan_last;

  // sample count modulo the scan length, zero meaning a full scan
  always_comb begin
    cnt_diff = CNT_W'(sample_index) - CNT_W'(segment_start);
    if (sample_index < segment_start) begin
      cnt_diff = cnt_diff + CNT_W'(MAX_SAMPLES);
    end
    count = (cnt_diff == '0) ? CNT_W'(MAX_SAMPLES) : cnt_diff;
    seg_end = (sample_index == '0) ? IDX_W'(MAX_SAMPLES - 1) : IDX_W'(sample_index - 1'b1);
  end

  rsn_div #(
    .DIV_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (segment_sum),
    .divisor  (count),
    .res      (div_res)
  );

  assign mean = (|div_res.quot[SUM_W-1:RANGE_W]) ? RANGE_SAT : div_res.quot[RANGE_W-1:0];
  assign in_bound = (CW'(segment_start) < CW'(low_angle_bound)) ||
                    (CW'(seg_end) > CW'(high_angle_bound));
  assign sum_add  = {1'b0, segment_sum} + (SUM_W + 1)'(range_mm);

  always_comb begin
    sample_index_next   = sample_index;
    in_segment_next     = in_segment;
    segment_start_next  = segment_start;
    segment_sum_next    = segment_sum;
    any_segment_next    = any_segment;
    first_start_next    = first_start;
    first_end_next      = first_end;
    first_dist_next     = first_dist;
    have_candidate_next = have_candidate;
    best_start_next     = best_start;
    best_end_next       = best_end;
    best_dist_next      = best_dist;

    if (accept && !closes) begin
      if (opens) begin
        in_segment_next    = 1'b1;
        segment_start_next = sample_index;
        segment_sum_next   = SUM_W'(range_mm);
      end else if (in_segment) begin
        segment_sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      end
    end

    if (state == ST_DIV && div_res.done) begin
      if (!any_segment) begin
        any_segment_next = 1'b1;
        first_start_next = segment_start;
        first_end_next   = seg_end;
        first_dist_next  = mean;
      end
      if (in_bound && (!have_candidate || mean < best_dist)) begin
        have_candidate_next = 1'b1;
        best_start_next     = segment_start;
        best_end_next       = seg_end;
        best_dist_next      = mean;
      end
      in_segment_next  = 1'b0;
      segment_sum_next = '0;
    end

    if (finish) begin
      sample_index_next = (32'(sample_index) + 1 >= MAX_SAMPLES) ? '0 :
                          IDX_W'(sample_index + 1'b1);
    end

    // result from the updated scan state
    if (have_candidate_next) begin
      found_next       = 1'b1;
      start_angle_next = ANG_W'(best_start_next);
      end_angle_next   = ANG_W'(best_end_next);
      distance_mm_next = best_dist_next;
    end else if (any_segment_next) begin
      found_next       = 1'b1;
      start_angle_next = ANG_W'(first_start_next);
      end_angle_next   = ANG_W'(first_end_next);
      distance_mm_next = first_dist_next;
    end else begin
      found_next       = 1'b0;
      start_angle_next = '0;
      end_angle_next   = '0;
      distance_mm_next = RANGE_SAT;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_range        <= MIN_RANGE_RST;
      max_range        <= MAX_RANGE_RST;
      low_angle_bound  <= LOW_BOUND_RST;
      high_angle_bound <= HIGH_BOUND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_RANGE:  min_range        <= cfg_data;
        REG_MAX_RANGE:  max_range        <= cfg_data;
        REG_LOW_BOUND:  low_angle_bound  <= cfg_data[ANG_W-1:0];
        REG_HIGH_BOUND: high_angle_bound <= cfg_data[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, scan state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      last_q         <= 1'b0;
      sample_index   <= '0;
      in_segment     <= 1'b0;
      segment_start  <= '0;
      segment_sum    <= '0;
      any_segment    <= 1'b0;
      first_start    <= '0;
      first_end      <= '0;
      first_dist     <= '0;
      have_candidate <= 1'b0;
      best_start     <= '0;
      best_end       <= '0;
      best_dist      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            last_q <= last_sample;
            if (closes) begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_res.done) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      // a new result may replace one that drains in the same cycle
      if (emit) begin
        out_valid   <= 1'b1;
        found       <= found_next;
        start_angle <= start_angle_next;
        end_angle   <= end_angle_next;
        distance_mm <= distance_mm_next;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (emit) begin
        // new scan
        sample_index   <= '0;
        in_segment     <= 1'b0;
        segment_start  <= '0;
        segment_sum    <= '0;
        any_segment    <= 1'b0;
        first_start    <= '0;
        first_end      <= '0;
        first_dist     <= '0;
        have_candidate <= 1'b0;
        best_start     <= '0;
        best_end       <= '0;
        best_dist      <= '0;
      end else begin
        sample_index   <= sample_index_next;
        in_segment     <= in_segment_next;
        segment_start  <= segment_start_next;
        segment_sum    <= segment_sum_next;
        any_segment    <= any_segment_next;
        first_start    <= first_start_next;
        first_end      <= first_end_next;
        first_dist     <= first_dist_next;
        have_candidate <= have_candidate_next;
        best_start     <= best_start_next;
        best_end       <= best_end_next;
        best_dist      <= best_dist_next;
      end
    end
  end

  // divider only reports while a closing item is held
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == ST_DIV)
    else $error("divider finished outside of a segment close");

  // output register was drained when a closing last item was taken
  a_out_free_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && last_q) |-> !out_valid)
    else $error("result pending while the closing last item is in progress");

  // a finished close leaves no open segment
  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_res.done) |=> !in_segment)
    else $error("segment still open after close");

  // a not-found item carries the saturated distance and zero angles
  a_not_found_fmt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (distance_mm == RANGE_SAT && start_angle == '0
                               && end_angle == '0))
    else $error("not-found item with bad payload");

endmodule

`default_nettype wire

/* tb/sv/tb_range_scan_nearest_segment_top.sv */
// self-checking testbench for range_scan_nearest_segment_top: valid/ready driver and monitor,
// scan predictor, directed and random scans over several register settings
// depends on rsn_pkg and the range_scan_nearest_segment_top rtl
`timescale 1ns / 1ps

module tb_range_scan_nearest_segment_top;
  import rsn_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // settle time after a drain, well past the hold of a closing sample
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic [RANGE_W-1:0] mm;
    logic               is_last;
  } sample_item_t;

  typedef struct {
    logic               found;
    logic [ANG_W-1:0]   start_ang;
    logic [ANG_W-1:0]   end_ang;
    logic [RANGE_W-1:0] avg_mm;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [RANGE_W-1:0]   range_mm = '0;
  logic                 last_sample = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 found;
  logic [ANG_W-1:0]     start_angle;
  logic [ANG_W-1:0]     end_angle;
  logic [RANGE_W-1:0]   distance_mm;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MIN_RANGE;
  logic [RANGE_W-1:0]   cfg_data = '0;

  range_scan_nearest_segment_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .range_mm   (range_mm),
    .last_sample(last_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .start_angle(start_angle),
    .end_angle  (end_angle),
    .distance_mm(distance_mm),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // samples waiting to be offered, and scan results still owed by the block
  sample_item_t pending_items[$];
  scan_result_t expected_results[$];

  int error_count = 0;
  int items_taken = 0;
  int results_seen = 0;
  int settings_count = 0;
  int cycle_count = 0;

  // register mirror, follows every write
  logic [RANGE_W-1:0] cfg_min_range = MIN_RANGE_RST;
  logic [RANGE_W-1:0] cfg_max_range = MAX_RANGE_RST;
  logic [ANG_W-1:0]   cfg_low_bound = LOW_BOUND_RST;
  logic [ANG_W-1:0]   cfg_high_bound = HIGH_BOUND_RST;

  // scan state of the predictor
  logic [ANG_W-1:0]   scan_pos;
  logic               seg_open;
  logic [ANG_W-1:0]   seg_begin;
  logic [SUM_W-1:0]   seg_acc;
  logic               seen_seg;
  logic [ANG_W-1:0]   first_begin, first_stop;
  logic [RANGE_W-1:0] first_mean;
  logic               have_pick;
  logic [ANG_W-1:0]   pick_begin, pick_stop;
  logic [RANGE_W-1:0] pick_mean;

  function automatic void restart_scan();
    scan_pos = '0;
    seg_open = 1'b0;
    seg_begin = '0;
    seg_acc = '0;
    seen_seg = 1'b0;
    first_begin = '0;
    first_stop = '0;
    first_mean = '0;
    have_pick = 1'b0;
    pick_begin = '0;
    pick_stop = '0;
    pick_mean = '0;
  endfunction

  // segment close: mean over the sample count, first and nearest in-bound tracking
  function automatic void close_seg();
    logic [ANG_W-1:0]   span_bits;
    logic [ANG_W-1:0]   seg_stop;
    int unsigned        span_len;
    int unsigned        mean_full;
    logic [RANGE_W-1:0] mean_sat;
    span_bits = scan_pos - seg_begin;
    // the 9-bit index wraps, so an all-zero span means a full 512 samples
    span_len = (span_bits == 0) ? MAX_SAMPLES_DEF : span_bits;
    seg_stop = scan_pos - 1'b1;
    mean_full = seg_acc / span_len;
    mean_sat = (mean_full > RANGE_SAT) ? RANGE_SAT : mean_full[RANGE_W-1:0];
    if (!seen_seg) begin
      seen_seg = 1'b1;
      first_begin = seg_begin;
      first_stop = seg_stop;
      first_mean = mean_sat;
    end
    if (seg_begin < cfg_low_bound || seg_stop > cfg_high_bound) begin
      // strict compare keeps the earliest segment on equal distance
      if (!have_pick || mean_sat < pick_mean) begin
        have_pick = 1'b1;
        pick_begin = seg_begin;
        pick_stop = seg_stop;
        pick_mean = mean_sat;
      end
    end
    seg_open = 1'b0;
    seg_acc = '0;
  endfunction

  // advance the scan by one sample; a last sample yields the scan result
  function automatic void step_scan(input logic [RANGE_W-1:0] mm, input logic is_last,
                                    output bit produced, output scan_result_t res);
    logic [SUM_W:0] acc_wide;
    if (!seg_open) begin
      if (mm > cfg_min_range && mm < cfg_max_range) begin
        seg_open = 1'b1;
        seg_begin = scan_pos;
        seg_acc = SUM_W'(mm);
      end
    end else if (mm > cfg_max_range) begin
      close_seg();
    end else begin
      // a range equal to max_range lands here and just accumulates
      acc_wide = seg_acc + mm;
      seg_acc = (acc_wide > SUM_MAX) ? SUM_MAX : acc_wide[SUM_W-1:0];
    end
    scan_pos = scan_pos + 1'b1;
    produced = is_last;
    if (have_pick) begin
      res = '{1'b1, pick_begin, pick_stop, pick_mean};
    end else if (seen_seg) begin
      res = '{1'b1, first_begin, first_stop, first_mean};
    end else begin
      res = '{1'b0, '0, '0, RANGE_SAT};
    end
    // an open segment is simply dropped here
    if (is_last) restart_scan();
  endfunction

  initial restart_scan();

  // cycle count and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               expected_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // a stretch with no random gaps on either side
  wire quiet_window = (cycle_count >= 1500) && (cycle_count < 4500);

  // sample driver: valid holds with a stable payload until the item is taken
  always @(posedge clk) begin : sample_driver
    sample_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() != 0 && (quiet_window || $urandom_range(99) >= 8)) begin
        nxt = pending_items.pop_front();
        in_valid <= 1'b1;
        range_mm <= nxt.mm;
        last_sample <= nxt.is_last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, plus one long hold-off so the block backs up
  int  hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin : result_receiver
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 14) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_window || ($urandom_range(99) >= 8);
    end
  end

  // monitor: predict on every accepted sample, check every accepted result
  always @(posedge clk) begin : scan_monitor
    scan_result_t want;
    bit           produced;
    if (!rst) begin
      if (in_valid && in_ready) begin
        items_taken++;
        step_scan(range_mm, last_sample, produced, want);
        if (produced) expected_results.insert(expected_results.size(), want);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: found %0d start %0d end %0d dist %0d",
                 found, start_angle, end_angle, distance_mm);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            error_count++;
          end
          if (start_angle !== want.start_ang) begin
            $error("start_angle: expected %0d, got %0d", want.start_ang, start_angle);
            error_count++;
          end
          if (end_angle !== want.end_ang) begin
            $error("end_angle: expected %0d, got %0d", want.end_ang, end_angle);
            error_count++;
          end
          if (distance_mm !== want.avg_mm) begin
            $error("distance_mm: expected %0d, got %0d", want.avg_mm, distance_mm);
            error_count++;
          end
        end
      end
    end
  end

  task automatic add_sample(input logic [RANGE_W-1:0] mm, input logic is_last);
    sample_item_t it;
    it.mm = mm;
    it.is_last = is_last;
    pending_items.insert(pending_items.size(), it);
  endtask

  // one register write per cycle, mirror kept in step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RANGE_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MIN_RANGE:  cfg_min_range = val;
      REG_MAX_RANGE:  cfg_max_range = val;
      REG_LOW_BOUND:  cfg_low_bound = val[ANG_W-1:0];
      REG_HIGH_BOUND: cfg_high_bound = val[ANG_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_settings(input int min_mm, input int max_mm, input int lo, input int hi);
    write_reg(REG_MIN_RANGE, RANGE_W'(min_mm));
    write_reg(REG_MAX_RANGE, RANGE_W'(max_mm));
    write_reg(REG_LOW_BOUND, RANGE_W'(lo));
    write_reg(REG_HIGH_BOUND, RANGE_W'(hi));
    cfg_we <= 1'b0;
    settings_count++;
    @(posedge clk);
  endtask

  // block is idle once every sample is taken and every result has come back
  task automatic drain_scans();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random range biased toward segment-forming values under the current settings
  function automatic logic [RANGE_W-1:0] pick_range();
    int roll;
    roll = $urandom_range(99);
    if (roll < 40 && int'(cfg_max_range) > int'(cfg_min_range) + 1)
      return RANGE_W'($urandom_range(int'(cfg_max_range) - 1, int'(cfg_min_range) + 1));
    if (roll < 55 && cfg_max_range != RANGE_SAT)
      return RANGE_W'($urandom_range(RANGE_SAT, int'(cfg_max_range) + 1));
    if (roll < 60) return cfg_max_range;
    if (roll < 65) return cfg_min_range;
    if (roll < 75) return RANGE_W'($urandom_range(int'(cfg_min_range), 0));
    if (roll < 85) return RANGE_SAT;
    return RANGE_W'($urandom_range(RANGE_SAT, 0));
  endfunction

  task automatic queue_random_scans(input int n_scans);
    int len;
    for (int s = 0; s < n_scans; s++) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(20, 1);
      for (int i = 0; i < len; i++) add_sample(pick_range(), i == len - 1);
    end
  endtask

  initial begin : stimulus
    int min_mm;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: range at min and max edges, drop of an open segment at scan end
    add_sample(16'd0, 1'b0);
    add_sample(16'd10, 1'b0);
    add_sample(16'd11, 1'b0);
    add_sample(16'd3000, 1'b0);
    add_sample(16'd2999, 1'b0);
    add_sample(16'd3001, 1'b0);
    add_sample(RANGE_SAT, 1'b0);
    add_sample(16'd500, 1'b1);
    // scan with no segment at all
    add_sample(RANGE_SAT, 1'b0);
    add_sample(16'd0, 1'b1);
    // tie on distance, and a closing last sample
    add_sample(16'd100, 1'b0);
    add_sample(16'd4000, 1'b0);
    add_sample(16'd100, 1'b0);
    add_sample(16'd4000, 1'b1);
    drain_scans();

    // bounds at their extremes: nothing in bound, so the first segment is reported
    apply_settings(10, 3000, 0, 511);
    add_sample(16'd200, 1'b0);
    add_sample(16'd4000, 1'b0);
    add_sample(16'd50, 1'b0);
    add_sample(16'hEA60, 1'b1);
    drain_scans();

    // register extremes where no segment can open
    apply_settings(65535, 65535, 0, 0);
    queue_random_scans(2);
    drain_scans();
    apply_settings(0, 0, 511, 511);
    queue_random_scans(2);
    drain_scans();

    // random settings, bounds near the scan start or anywhere
    for (int k = 0; k < 4; k++) begin
      min_mm = $urandom_range(300, 0);
      if (k % 2 == 0)
        apply_settings(min_mm, $urandom_range(5000, min_mm + 2), $urandom_range(40, 0),
                       $urandom_range(40, 0));
      else
        apply_settings(min_mm, $urandom_range(5000, min_mm + 2), $urandom_range(511, 0),
                       $urandom_range(511, 0));
      queue_random_scans(7);
      drain_scans();
    end

    // back to the reset values
    apply_settings(MIN_RANGE_RST, MAX_RANGE_RST, LOW_BOUND_RST, HIGH_BOUND_RST);
    queue_random_scans(4);
    drain_scans();

    $display("covered %0d samples and %0d scan results over %0d register settings,",
             items_taken, results_seen, settings_count);
    $display("including range edges, distance ties, dropped segments and a long output stall");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/rsn_pkg.sv
src/rsn_div.sv
src/range_scan_nearest_segment_top.sv
tb/sv/tb_range_scan_nearest_segment_top.sv
